@@ rtl/pidaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and saturation helpers for the PID controller with
// integral clamp.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W     = 16;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = DATA_W + 2;
    localparam int FRAC_W     = 8;
    localparam int LIM_W      = DATA_W + FRAC_W;
    localparam int TERM_W     = 32;
    localparam int WIDE_W     = TERM_W + 2;
    localparam int ITERM_W    = 25;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_SETPOINT = 3'd3,
        REG_OUT_MAX  = 3'd4,
        REG_OUT_MIN  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] out_max;
        logic signed [DATA_W-1:0] out_min;
    } cfg_t;

    // Stage from the product register to the clamp stage.
    typedef struct packed {
        logic                     valid;
        logic signed [TERM_W-1:0] p_term;
        logic signed [TERM_W:0]   i_prod;
        logic signed [TERM_W-1:0] d_term;
    } prod_t;

    function automatic logic signed [TERM_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
        logic signed [TERM_W-1:0] r;
        if ((v[WIDE_W-1:TERM_W-1] == '0) || (v[WIDE_W-1:TERM_W-1] == '1))
        begin
            r = v[TERM_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(TERM_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(TERM_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [ITERM_W-1:0] sat_s25(input logic signed [TERM_W-1:0] v);
        logic signed [ITERM_W-1:0] r;
        if ((v[TERM_W-1:ITERM_W-1] == '0) || (v[TERM_W-1:ITERM_W-1] == '1))
        begin
            r = v[ITERM_W-1:0];
        end
        else if (v[TERM_W-1])
        begin
            r = {1'b1, {(ITERM_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ITERM_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ rtl/pidaw_if.sv @@
// ----------------------------------------------------------------------------
// pidaw_if
// Valid/ready channels for measurement beats in and drive beats out.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface pidaw_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic signed [31:0] p_term;
    logic signed [24:0] i_term;
    logic signed [31:0] d_term;

    modport source (output valid, output drive, output p_term, output i_term,
                    output d_term, input ready);
    modport sink   (input valid, input drive, input p_term, input i_term,
                    input d_term, output ready);
endinterface

@@ rtl/pidaw_regs.sv @@
// ----------------------------------------------------------------------------
// pidaw_regs
// APB-style configuration registers: gains, setpoint and output limits.
// ----------------------------------------------------------------------------
module pidaw_regs
    import pidaw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    reg_idx_t                 idx;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_val;
    logic signed [DATA_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[DATA_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_P:   cfg_next.gain_p   = wr_val;
                REG_GAIN_I:   cfg_next.gain_i   = wr_val;
                REG_GAIN_D:   cfg_next.gain_d   = wr_val;
                REG_SETPOINT: cfg_next.setpoint = wr_val;
                REG_OUT_MAX:  cfg_next.out_max  = wr_val;
                REG_OUT_MIN:  cfg_next.out_min  = wr_val;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN_P:   rd_val = cfg_reg.gain_p;
            REG_GAIN_I:   rd_val = cfg_reg.gain_i;
            REG_GAIN_D:   rd_val = cfg_reg.gain_d;
            REG_SETPOINT: rd_val = cfg_reg.setpoint;
            REG_OUT_MAX:  rd_val = cfg_reg.out_max;
            REG_OUT_MIN:  rd_val = cfg_reg.out_min;
            default:      rd_val = '0;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p   <= 16'sd256;
            cfg_reg.gain_i   <= '0;
            cfg_reg.gain_d   <= '0;
            cfg_reg.setpoint <= '0;
            cfg_reg.out_max  <= 16'sd32767;
            cfg_reg.out_min  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pidaw_front.sv @@
// ----------------------------------------------------------------------------
// pidaw_front
// Error, error difference and the three gain products, registered.
// ----------------------------------------------------------------------------
module pidaw_front
    import pidaw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    pidaw_in_if.sink    in_ch,
    input  logic        take,
    output prod_t       prod
);

    logic signed [DATA_W-1:0]  target;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [TERM_W:0]    p_raw;
    logic signed [TERM_W:0]    i_raw;
    logic signed [WIDE_W-1:0]  d_raw;
    logic                      free;
    logic                      accept;

    logic                      seeded_reg;
    logic                      seeded_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic signed [TERM_W-1:0]  p_term_reg;
    logic signed [TERM_W-1:0]  p_term_next;
    logic signed [TERM_W:0]    i_prod_reg;
    logic signed [TERM_W:0]    i_prod_next;
    logic signed [TERM_W-1:0]  d_term_reg;
    logic signed [TERM_W-1:0]  d_term_next;

    assign free        = !valid_reg || take;
    assign in_ch.ready = free;
    assign accept      = in_ch.valid && free;

    // With inverted limits, a setpoint above out_max gets out_max, else out_min.
    always_comb
    begin
        if (cfg.setpoint > cfg.out_max)
        begin
            target = cfg.out_max;
        end
        else if (cfg.setpoint < cfg.out_min)
        begin
            target = cfg.out_min;
        end
        else
        begin
            target = cfg.setpoint;
        end
    end

    assign err = ERR_W'(target) - ERR_W'(in_ch.measurement);

    // The first beat after reset seeds the previous error, so its difference is zero.
    assign diff  = seeded_reg ? (DIFF_W'(err) - DIFF_W'(prev_err_reg)) : '0;
    assign p_raw = (TERM_W+1)'(cfg.gain_p) * (TERM_W+1)'(err);
    assign i_raw = (TERM_W+1)'(cfg.gain_i) * (TERM_W+1)'(err);
    assign d_raw = WIDE_W'(cfg.gain_d) * WIDE_W'(diff);

    always_comb
    begin
        seeded_next   = seeded_reg;
        prev_err_next = prev_err_reg;
        valid_next    = valid_reg;
        p_term_next   = p_term_reg;
        i_prod_next   = i_prod_reg;
        d_term_next   = d_term_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            seeded_next   = 1'b1;
            prev_err_next = err;
            valid_next    = 1'b1;
            p_term_next   = sat_s32(WIDE_W'(p_raw));
            i_prod_next   = i_raw;
            d_term_next   = sat_s32(d_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg   <= 1'b0;
            prev_err_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            seeded_reg   <= seeded_next;
            prev_err_reg <= prev_err_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_term_reg <= p_term_next;
        i_prod_reg <= i_prod_next;
        d_term_reg <= d_term_next;
    end

    assign prod.valid  = valid_reg;
    assign prod.p_term = p_term_reg;
    assign prod.i_prod = i_prod_reg;
    assign prod.d_term = d_term_reg;

endmodule

@@ rtl/pidaw_back.sv @@
// ----------------------------------------------------------------------------
// pidaw_back
// Integral update with anti-windup clamp, output sum and limit, and the
// result register.
// ----------------------------------------------------------------------------
module pidaw_back
    import pidaw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  prod_t        prod,
    output logic         take,
    pidaw_out_if.source  out_ch
);

    logic signed [LIM_W-1:0]   max_q;
    logic signed [LIM_W-1:0]   min_q;
    logic signed [TERM_W-1:0]  acc_sat;
    logic signed [WIDE_W-1:0]  hi_raw;
    logic signed [WIDE_W-1:0]  lo_raw;
    logic signed [WIDE_W-1:0]  hi_c;
    logic signed [WIDE_W-1:0]  lo_c;
    logic signed [TERM_W-1:0]  acc_new;
    logic signed [WIDE_W-1:0]  sum;
    logic signed [LIM_W-1:0]   lim;

    logic signed [TERM_W-1:0]  int_acc_reg;
    logic signed [TERM_W-1:0]  int_acc_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DATA_W-1:0]  drive_reg;
    logic signed [DATA_W-1:0]  drive_next;
    logic signed [TERM_W-1:0]  p_term_reg;
    logic signed [TERM_W-1:0]  p_term_next;
    logic signed [ITERM_W-1:0] i_term_reg;
    logic signed [ITERM_W-1:0] i_term_next;
    logic signed [TERM_W-1:0]  d_term_reg;
    logic signed [TERM_W-1:0]  d_term_next;

    assign take  = prod.valid && (!out_valid_reg || out_ch.ready);
    assign max_q = $signed({cfg.out_max, {FRAC_W{1'b0}}});
    assign min_q = $signed({cfg.out_min, {FRAC_W{1'b0}}});

    assign acc_sat = sat_s32(WIDE_W'(int_acc_reg) + WIDE_W'(prod.i_prod));
    assign hi_raw  = WIDE_W'(max_q) - WIDE_W'(prod.p_term);
    assign lo_raw  = WIDE_W'(min_q) - WIDE_W'(prod.p_term);
    assign hi_c    = hi_raw[WIDE_W-1] ? '0 : hi_raw;
    assign lo_c    = (!lo_raw[WIDE_W-1] && (lo_raw != '0)) ? '0 : lo_raw;

    // The window always holds zero, and a clamped value never leaves the
    // 32-bit range since it only moves toward zero from the saturated sum.
    always_comb
    begin
        if (WIDE_W'(acc_sat) > hi_c)
        begin
            acc_new = hi_c[TERM_W-1:0];
        end
        else if (WIDE_W'(acc_sat) < lo_c)
        begin
            acc_new = lo_c[TERM_W-1:0];
        end
        else
        begin
            acc_new = acc_sat;
        end
    end

    assign sum = WIDE_W'(prod.p_term) + WIDE_W'(acc_new) + WIDE_W'(prod.d_term);

    always_comb
    begin
        if (sum > WIDE_W'(max_q))
        begin
            lim = max_q;
        end
        else if (sum < WIDE_W'(min_q))
        begin
            lim = min_q;
        end
        else
        begin
            lim = sum[LIM_W-1:0];
        end
    end

    always_comb
    begin
        int_acc_next   = int_acc_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        p_term_next    = p_term_reg;
        i_term_next    = i_term_reg;
        d_term_next    = d_term_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            int_acc_next   = acc_new;
            out_valid_next = 1'b1;
            drive_next     = lim[LIM_W-1:FRAC_W];
            p_term_next    = prod.p_term;
            i_term_next    = sat_s25(acc_new);
            d_term_next    = prod.d_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            int_acc_reg   <= int_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg  <= drive_next;
        p_term_reg <= p_term_next;
        i_term_reg <= i_term_next;
        d_term_reg <= d_term_next;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.drive  = drive_reg;
    assign out_ch.p_term = p_term_reg;
    assign out_ch.i_term = i_term_reg;
    assign out_ch.d_term = d_term_reg;

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("result register not loaded after a beat was taken");

    a_int_window: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ((WIDE_W'(acc_new) <= hi_c) && (WIDE_W'(acc_new) >= lo_c)))
        else $error("integral left its anti-windup window");

    a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (cfg.out_max >= cfg.out_min)) |=>
        ((drive_reg <= $past(cfg.out_max)) && (drive_reg >= $past(cfg.out_min))))
        else $error("drive outside the output limits");

endmodule

@@ rtl/pid_controller_antiwindup_core.sv @@
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_core
// Path: a taken beat passes the product register, then the result register.
// Throughput: one beat per cycle unless out_ch stalls; the product register and
// the result register are a two-stage pipeline; the integral loops in stage two.
// Reset: clears the pipeline, the integral and the seed flag, and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_core
    import pidaw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pidaw_in_if.sink           in_ch,
    pidaw_out_if.source        out_ch
);

    cfg_t  cfg;
    prod_t prod;
    logic  take;

    pidaw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidaw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .in_ch (in_ch),
        .take  (take),
        .prod  (prod)
    );

    pidaw_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .prod   (prod),
        .take   (take),
        .out_ch (out_ch)
    );

endmodule
